FILE: sv/phbm_pkg.sv
package phbm_pkg;

	localparam int SCAN_CAP_DEF     = 1024;
	localparam int RECORD_COUNT_DEF = 65536;
	localparam int CORDIC_STEPS_DEF = 24;

	localparam int Z_W = 36;
	localparam int IN_W = 184;
	localparam int OUT_W = 80;

	localparam logic [32:0] DEG7_K = 33'd8048910490;
	localparam logic [23:0] DIST_K = 24'd12742000;
	localparam logic [29:0] TENTHS_K = 30'd600789793;

	localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;
	localparam logic signed [63:0] ONE_Q60  = 64'sd1152921504606846976;
	localparam logic signed [63:0] EPS_Q60  = 64'sd1152921504607;
	localparam logic signed [33:0] LON_HALF = 34'sd1800000000;
	localparam logic signed [33:0] LON_FULL = 34'sd3600000000;
	localparam logic [11:0] FULL_TURN = 12'd3600;
	localparam logic [11:0] HALF_TURN = 12'd1800;

	localparam logic [1:0] REG_RADIUS  = 2'd0;
	localparam logic [1:0] REG_MAX_TOL = 2'd1;
	localparam logic [1:0] REG_MIN_TOL = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_RAD_MUL, S_RAD_RND, S_RAD_LOAD, S_CORDIC, S_CDONE,
		S_DA, S_DB, S_DC, S_DD, S_DE, S_DF, S_SQRT, S_DLOAD, S_DZ, S_DQ, S_DCMP,
		S_BA, S_BB, S_BC, S_BD, S_BE, S_BF, S_BLOAD, S_BG, S_BH, S_HEAD, S_FIN
	} state_t;

	typedef enum logic [2:0] {
		JOB_DLAT, JOB_DLON, JOB_VLAT, JOB_PLAT, JOB_DBR, JOB_ATAN_DIST, JOB_ATAN_BEAR
	} job_t;

	function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			5'd0: v = 36'sd843314856;
			5'd1: v = 36'sd497837829;
			5'd2: v = 36'sd263043836;
			5'd3: v = 36'sd133525158;
			5'd4: v = 36'sd67021686;
			5'd5: v = 36'sd33543515;
			5'd6: v = 36'sd16775850;
			5'd7: v = 36'sd8388437;
			5'd8: v = 36'sd4194282;
			5'd9: v = 36'sd2097149;
			5'd10: v = 36'sd1048575;
			5'd11: v = 36'sd524287;
			5'd12: v = 36'sd262143;
			5'd13: v = 36'sd131071;
			5'd14: v = 36'sd65535;
			5'd15: v = 36'sd32767;
			5'd16: v = 36'sd16383;
			5'd17: v = 36'sd8191;
			5'd18: v = 36'sd4095;
			5'd19: v = 36'sd2047;
			5'd20: v = 36'sd1023;
			5'd21: v = 36'sd511;
			5'd22: v = 36'sd255;
			5'd23: v = 36'sd127;
			5'd24: v = 36'sd63;
			5'd25: v = 36'sd31;
			5'd26: v = 36'sd15;
			5'd27: v = 36'sd7;
			5'd28: v = 36'sd3;
			5'd29: v = 36'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/proximity_heading_best_match_top.sv
// Channel   Direction  Handshake                      Content
// config    in         psel/penable/pwrite, pready=1  radius, max and min tolerance
// s_axis    in         s_axis_tvalid/s_axis_tready    one candidate item, tlast ends search
// m_axis    out        m_axis_tvalid/m_axis_tready    search summary on the last item
//
// One CORDIC unit, one multiplier and one root stepper are shared under a sequencer.
// Every checked item runs the distance path, and one needing a computed bearing also runs
// the bearing path; a skipped item goes straight from the check to the finish.
// The CORDIC iterations and the two 31-step roots set most of the time an item takes.
// Reset clears all control and search state; the block then accepts items at once.
// A waiting summary stalls only the next last item, never the ones before it.
module proximity_heading_best_match_top #(
	parameter int SCAN_CAP     = phbm_pkg::SCAN_CAP_DEF,
	parameter int RECORD_COUNT = phbm_pkg::RECORD_COUNT_DEF,
	parameter int CORDIC_STEPS = phbm_pkg::CORDIC_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// vehicle_lat, vehicle_lon, vehicle_course, point_lat, point_lon,
	// point_bearing, point_tolerance, point_type, point_index
	input  logic [phbm_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// match_found, best_id, best_distance_m, best_type, best_heading_delta,
	// candidates_checked, match_count, cap_reached
	output logic [phbm_pkg::OUT_W-1:0] m_axis_tdata
);

	localparam int CNT_W = $clog2(SCAN_CAP + 1);
	localparam int IT_W  = $clog2(CORDIC_STEPS);
	localparam int ZW    = phbm_pkg::Z_W;

	phbm_pkg::state_t state_q, state_d;
	phbm_pkg::job_t   job_q;

	logic [15:0] radius_q;
	logic [7:0]  max_tol_q, min_tol_q;

	logic signed [30:0] vlat_q, plat_q;
	logic signed [31:0] vlon_q, plon_q;
	logic [11:0]        course_q;
	logic signed [12:0] pbear_q;
	logic [7:0]         ptol_q, ptype_q;
	logic [15:0]        pidx_q;
	logic               last_q;

	logic signed [32:0] dlat_q, dlon_q;
	logic signed [69:0] prod_q;
	logic signed [ZW-1:0] r_q, cz_q;
	logic signed [63:0] cx_q, cy_q, acc_q, yb_q, xb_q;
	logic               rot_q, neg_q, zneg_q;
	logic [IT_W-1:0]    iter_q;
	logic signed [31:0] sp_q, sl_q, s1_q, c1_q, s2_q, c2_q, sd_q, cd_q, t1_q, t2_q;
	logic [60:0]        a_q, sq_v_q;
	logic [61:0]        sq_r_q;
	logic [4:0]         sq_k_q;
	logic               sq_sel_q;
	logic [30:0]        sa_q, ca_q;
	logic [31:0]        dist_q;
	logic [11:0]        bear_q;

	logic [31:0]        best_dist_q;
	logic [16:0]        best_id_q;
	logic [7:0]         best_type_q;
	logic [10:0]        best_delta_q;
	logic [CNT_W-1:0]   checked_q, matched_q;
	logic               cap_q;
	logic               m_valid_q;
	logic [phbm_pkg::OUT_W-1:0] m_data_q;

	logic signed [34:0] mul_a, mul_b;
	logic signed [32:0] rad_val;
	logic [32:0]        rad_mag;
	logic               sh33;
	logic [69:0]        rnd_sum;
	logic [33:0]        rnd_p;
	logic signed [ZW-1:0] rad_r;
	logic signed [63:0] xs, ys, cx_n, cy_n, sy, sx;
	logic signed [ZW-1:0] cz_n, at;
	logic               up, cordic_last;
	logic [61:0]        sq_bit, sq_trial, sq_r_n;
	logic [60:0]        sq_v_n;
	logic               sq_take;
	logic signed [63:0] a_sum, xb_n;
	logic [60:0]        a_cl;
	logic signed [33:0] dlon_raw, dlon_w;
	logic [69:0]        dq_sum, t_sum;
	logic [31:0]        dq;
	logic [19:0]        t_raw;
	logic [11:0]        t_mod, bear_n;
	logic signed [ZW-1:0] zmag, zclip;
	logic               coincident, fixed, in_range, pass, idx_ok, cfg_wr, out_free;
	logic [11:0]        course_m, target, ad, delta, tol10;
	logic signed [12:0] diff;
	logic [7:0]         tol0, tol;
	logic [phbm_pkg::OUT_W-1:0] out_word;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign s_axis_tready = (state_q == phbm_pkg::S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		case (paddr[3:2])
			phbm_pkg::REG_RADIUS:  prdata = {16'b0, radius_q};
			phbm_pkg::REG_MAX_TOL: prdata = {24'b0, max_tol_q};
			phbm_pkg::REG_MIN_TOL: prdata = {24'b0, min_tol_q};
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		case (job_q)
			phbm_pkg::JOB_DLAT: rad_val = dlat_q;
			phbm_pkg::JOB_VLAT: rad_val = 33'(vlat_q);
			phbm_pkg::JOB_PLAT: rad_val = 33'(plat_q);
			default:            rad_val = dlon_q;
		endcase
	end

	always_comb begin
		rad_mag = rad_val[32] ? (~rad_val + 33'd1) : rad_val;
		sh33 = (job_q == phbm_pkg::JOB_DLAT) || (job_q == phbm_pkg::JOB_DLON);
		rnd_sum = prod_q + (sh33 ? (70'd1 << 32) : (70'd1 << 31));
		rnd_p = sh33 ? rnd_sum[66:33] : rnd_sum[65:32];
		rad_r = rad_val[32] ? -$signed({2'b0, rnd_p}) : $signed({2'b0, rnd_p});

		xs = cx_q >>> iter_q;
		ys = cy_q >>> iter_q;
		at = phbm_pkg::atan_q30(5'(iter_q));
		up = rot_q ? !cz_q[ZW-1] : cy_q[63];
		cx_n = up ? cx_q - ys : cx_q + ys;
		cy_n = up ? cy_q + xs : cy_q - xs;
		cz_n = up ? cz_q - at : cz_q + at;
		cordic_last = (iter_q == IT_W'(CORDIC_STEPS - 1));
		sy = neg_q ? -cy_q : cy_q;
		sx = neg_q ? -cx_q : cx_q;

		sq_bit = 62'd1 << {sq_k_q, 1'b0};
		sq_trial = sq_r_q + sq_bit;
		sq_take = {1'b0, sq_v_q} >= sq_trial;
		sq_v_n = sq_take ? sq_v_q - sq_trial[60:0] : sq_v_q;
		sq_r_n = sq_take ? (sq_r_q >> 1) + sq_bit : sq_r_q >> 1;

		a_sum = acc_q + prod_q[63:0];
		if (a_sum < 0) begin
			a_cl = '0;
		end else if (a_sum > phbm_pkg::ONE_Q60) begin
			a_cl = phbm_pkg::ONE_Q60[60:0];
		end else begin
			a_cl = a_sum[60:0];
		end

		dlon_raw = 34'(plon_q) - 34'(vlon_q);
		if (dlon_raw >= phbm_pkg::LON_HALF) begin
			dlon_w = dlon_raw - phbm_pkg::LON_FULL;
		end else if (dlon_raw < -phbm_pkg::LON_HALF) begin
			dlon_w = dlon_raw + phbm_pkg::LON_FULL;
		end else begin
			dlon_w = dlon_raw;
		end

		zclip = cz_q[ZW-1] ? '0 : cz_q;
		zmag = cz_q[ZW-1] ? -cz_q : cz_q;
		dq_sum = prod_q + 70'd8192;
		dq = (dq_sum[69:46] != '0) ? 32'hFFFF_FFFF : dq_sum[45:14];

		xb_n = acc_q - prod_q[63:0];
		coincident = (yb_q > -phbm_pkg::EPS_Q60) && (yb_q < phbm_pkg::EPS_Q60) &&
			(xb_q > -phbm_pkg::EPS_Q60) && (xb_q < phbm_pkg::EPS_Q60);

		t_sum = prod_q + (70'd1 << 49);
		t_raw = t_sum[69:50];
		t_mod = (t_raw >= 20'(phbm_pkg::FULL_TURN)) ?
			12'(t_raw - 20'(phbm_pkg::FULL_TURN)) : t_raw[11:0];
		bear_n = (zneg_q && t_mod != '0) ? phbm_pkg::FULL_TURN - t_mod : t_mod;

		in_range = dist_q <= {radius_q, 16'b0};
		fixed = !pbear_q[12] && (pbear_q[11:0] < phbm_pkg::FULL_TURN);
		idx_ok = 32'(pidx_q) < 32'(RECORD_COUNT);
		course_m = (course_q >= phbm_pkg::FULL_TURN) ? course_q - phbm_pkg::FULL_TURN : course_q;
		target = fixed ? pbear_q[11:0] : bear_q;
		diff = $signed({1'b0, course_m}) - $signed({1'b0, target});
		ad = diff[12] ? 12'(-diff) : diff[11:0];
		delta = (ad > phbm_pkg::HALF_TURN) ? phbm_pkg::FULL_TURN - ad : ad;
		tol0 = (ptol_q < min_tol_q) ? min_tol_q : ptol_q;
		if (fixed && ptol_q != '0) begin
			tol = (tol0 > max_tol_q) ? max_tol_q : tol0;
		end else begin
			tol = max_tol_q;
		end
		tol10 = {1'b0, tol, 3'b0} + {3'b0, tol, 1'b0};
		pass = delta <= tol10;

		out_word = {4'b0, cap_q, 11'(matched_q), 11'(checked_q), best_delta_q, best_type_q,
			(best_id_q != '0) ? best_dist_q[31:16] : 16'd0, best_id_q, best_id_q != '0};
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			phbm_pkg::S_RAD_MUL: begin
				mul_a = $signed({2'b0, rad_mag});
				mul_b = $signed({2'b0, phbm_pkg::DEG7_K});
			end
			phbm_pkg::S_DA: begin
				mul_a = 35'(sp_q);
				mul_b = 35'(sp_q);
			end
			phbm_pkg::S_DB: begin
				mul_a = 35'(c1_q);
				mul_b = 35'(c2_q);
			end
			phbm_pkg::S_DC: begin
				mul_a = 35'(sl_q);
				mul_b = 35'(sl_q);
			end
			phbm_pkg::S_DE: begin
				mul_a = 35'(t1_q);
				mul_b = 35'(t2_q);
			end
			phbm_pkg::S_DZ: begin
				mul_a = 35'(zclip);
				mul_b = $signed({11'b0, phbm_pkg::DIST_K});
			end
			phbm_pkg::S_BA: begin
				mul_a = 35'(sd_q);
				mul_b = 35'(c2_q);
			end
			phbm_pkg::S_BB: begin
				mul_a = 35'(c1_q);
				mul_b = 35'(s2_q);
			end
			phbm_pkg::S_BC: begin
				mul_a = 35'(s1_q);
				mul_b = 35'(c2_q);
			end
			phbm_pkg::S_BE: begin
				mul_a = 35'(t1_q);
				mul_b = 35'(cd_q);
			end
			phbm_pkg::S_BG: begin
				mul_a = 35'(zmag);
				mul_b = $signed({5'b0, phbm_pkg::TENTHS_K});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			phbm_pkg::S_IDLE: if (s_axis_tvalid) state_d = phbm_pkg::S_CHECK;
			phbm_pkg::S_CHECK: begin
				if (idx_ok && checked_q < CNT_W'(SCAN_CAP)) begin
					state_d = phbm_pkg::S_RAD_MUL;
				end else begin
					state_d = phbm_pkg::S_FIN;
				end
			end
			phbm_pkg::S_RAD_MUL:  state_d = phbm_pkg::S_RAD_RND;
			phbm_pkg::S_RAD_RND:  state_d = phbm_pkg::S_RAD_LOAD;
			phbm_pkg::S_RAD_LOAD: state_d = phbm_pkg::S_CORDIC;
			phbm_pkg::S_CORDIC:   if (cordic_last) state_d = phbm_pkg::S_CDONE;
			phbm_pkg::S_CDONE: begin
				case (job_q)
					phbm_pkg::JOB_PLAT:      state_d = phbm_pkg::S_DA;
					phbm_pkg::JOB_DBR:       state_d = phbm_pkg::S_BA;
					phbm_pkg::JOB_ATAN_DIST: state_d = phbm_pkg::S_DZ;
					phbm_pkg::JOB_ATAN_BEAR: state_d = phbm_pkg::S_BG;
					default:                 state_d = phbm_pkg::S_RAD_MUL;
				endcase
			end
			phbm_pkg::S_DA: state_d = phbm_pkg::S_DB;
			phbm_pkg::S_DB: state_d = phbm_pkg::S_DC;
			phbm_pkg::S_DC: state_d = phbm_pkg::S_DD;
			phbm_pkg::S_DD: state_d = phbm_pkg::S_DE;
			phbm_pkg::S_DE: state_d = phbm_pkg::S_DF;
			phbm_pkg::S_DF: state_d = phbm_pkg::S_SQRT;
			phbm_pkg::S_SQRT: if (sq_k_q == '0 && sq_sel_q) state_d = phbm_pkg::S_DLOAD;
			phbm_pkg::S_DLOAD: state_d = phbm_pkg::S_CORDIC;
			phbm_pkg::S_DZ: state_d = phbm_pkg::S_DQ;
			phbm_pkg::S_DQ: state_d = phbm_pkg::S_DCMP;
			phbm_pkg::S_DCMP: begin
				if (!in_range) begin
					state_d = phbm_pkg::S_FIN;
				end else if (fixed) begin
					state_d = phbm_pkg::S_HEAD;
				end else begin
					state_d = phbm_pkg::S_RAD_MUL;
				end
			end
			phbm_pkg::S_BA: state_d = phbm_pkg::S_BB;
			phbm_pkg::S_BB: state_d = phbm_pkg::S_BC;
			phbm_pkg::S_BC: state_d = phbm_pkg::S_BD;
			phbm_pkg::S_BD: state_d = phbm_pkg::S_BE;
			phbm_pkg::S_BE: state_d = phbm_pkg::S_BF;
			phbm_pkg::S_BF: state_d = phbm_pkg::S_BLOAD;
			phbm_pkg::S_BLOAD: state_d = coincident ? phbm_pkg::S_FIN : phbm_pkg::S_CORDIC;
			phbm_pkg::S_BG: state_d = phbm_pkg::S_BH;
			phbm_pkg::S_BH: state_d = phbm_pkg::S_HEAD;
			phbm_pkg::S_HEAD: state_d = phbm_pkg::S_FIN;
			phbm_pkg::S_FIN: if (!last_q || out_free) state_d = phbm_pkg::S_IDLE;
			default: state_d = phbm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phbm_pkg::S_IDLE;
			job_q <= phbm_pkg::JOB_DLAT;
			iter_q <= '0;
			sq_k_q <= '0;
			sq_sel_q <= 1'b0;
			radius_q <= 16'd500;
			max_tol_q <= 8'd35;
			min_tol_q <= 8'd5;
			best_dist_q <= '1;
			best_id_q <= '0;
			best_type_q <= '0;
			best_delta_q <= '0;
			checked_q <= '0;
			matched_q <= '0;
			cap_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (paddr[3:2])
					phbm_pkg::REG_RADIUS:  radius_q <= pwdata[15:0];
					phbm_pkg::REG_MAX_TOL: max_tol_q <= pwdata[7:0];
					phbm_pkg::REG_MIN_TOL: min_tol_q <= pwdata[7:0];
					default: ;
				endcase
			end
			if (state_q == phbm_pkg::S_FIN && last_q && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				phbm_pkg::S_CHECK: begin
					job_q <= phbm_pkg::JOB_DLAT;
					if (idx_ok) begin
						if (checked_q >= CNT_W'(SCAN_CAP)) begin
							cap_q <= 1'b1;
						end else begin
							checked_q <= checked_q + 1'b1;
						end
					end
				end
				phbm_pkg::S_RAD_LOAD: iter_q <= '0;
				phbm_pkg::S_CORDIC: iter_q <= iter_q + 1'b1;
				phbm_pkg::S_CDONE: begin
					case (job_q)
						phbm_pkg::JOB_DLAT: job_q <= phbm_pkg::JOB_DLON;
						phbm_pkg::JOB_DLON: job_q <= phbm_pkg::JOB_VLAT;
						phbm_pkg::JOB_VLAT: job_q <= phbm_pkg::JOB_PLAT;
						default: ;
					endcase
				end
				phbm_pkg::S_DF: begin
					sq_k_q <= 5'd30;
					sq_sel_q <= 1'b0;
				end
				phbm_pkg::S_SQRT: begin
					if (sq_k_q == '0) begin
						sq_k_q <= 5'd30;
						sq_sel_q <= 1'b1;
					end else begin
						sq_k_q <= sq_k_q - 1'b1;
					end
				end
				phbm_pkg::S_DLOAD: begin
					iter_q <= '0;
					job_q <= phbm_pkg::JOB_ATAN_DIST;
				end
				phbm_pkg::S_DCMP: job_q <= phbm_pkg::JOB_DBR;
				phbm_pkg::S_BLOAD: begin
					iter_q <= '0;
					job_q <= phbm_pkg::JOB_ATAN_BEAR;
				end
				phbm_pkg::S_HEAD: begin
					if (pass) begin
						matched_q <= matched_q + 1'b1;
						if (dist_q < best_dist_q) begin
							best_dist_q <= dist_q;
							best_id_q <= {1'b0, pidx_q} + 17'd1;
							best_type_q <= ptype_q;
							best_delta_q <= delta[10:0];
						end
					end
				end
				phbm_pkg::S_FIN: begin
					if (last_q && out_free) begin
						best_dist_q <= '1;
						best_id_q <= '0;
						best_type_q <= '0;
						best_delta_q <= '0;
						checked_q <= '0;
						matched_q <= '0;
						cap_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			phbm_pkg::S_IDLE: begin
				vlat_q <= s_axis_tdata[30:0];
				vlon_q <= s_axis_tdata[62:31];
				course_q <= s_axis_tdata[74:63];
				plat_q <= s_axis_tdata[105:75];
				plon_q <= s_axis_tdata[137:106];
				pbear_q <= s_axis_tdata[150:138];
				ptol_q <= s_axis_tdata[158:151];
				ptype_q <= s_axis_tdata[166:159];
				pidx_q <= s_axis_tdata[182:167];
				last_q <= s_axis_tlast;
			end
			phbm_pkg::S_CHECK: begin
				dlat_q <= 33'(plat_q) - 33'(vlat_q);
				dlon_q <= 33'(dlon_w);
			end
			phbm_pkg::S_RAD_RND: r_q <= rad_r;
			phbm_pkg::S_RAD_LOAD: begin
				cx_q <= phbm_pkg::GAIN_Q30;
				cy_q <= '0;
				rot_q <= 1'b1;
				if (r_q > phbm_pkg::HALF_PI_Q30) begin
					cz_q <= r_q - phbm_pkg::PI_Q30;
					neg_q <= 1'b1;
				end else if (r_q < -phbm_pkg::HALF_PI_Q30) begin
					cz_q <= r_q + phbm_pkg::PI_Q30;
					neg_q <= 1'b1;
				end else begin
					cz_q <= r_q;
					neg_q <= 1'b0;
				end
			end
			phbm_pkg::S_CORDIC: begin
				cx_q <= cx_n;
				cy_q <= cy_n;
				cz_q <= cz_n;
			end
			phbm_pkg::S_CDONE: begin
				case (job_q)
					phbm_pkg::JOB_DLAT: sp_q <= sy[31:0];
					phbm_pkg::JOB_DLON: sl_q <= sy[31:0];
					phbm_pkg::JOB_VLAT: begin
						s1_q <= sy[31:0];
						c1_q <= sx[31:0];
					end
					phbm_pkg::JOB_PLAT: begin
						s2_q <= sy[31:0];
						c2_q <= sx[31:0];
					end
					phbm_pkg::JOB_DBR: begin
						sd_q <= sy[31:0];
						cd_q <= sx[31:0];
					end
					default: ;
				endcase
			end
			phbm_pkg::S_DB: acc_q <= prod_q[63:0];
			phbm_pkg::S_DC: t1_q <= 32'(prod_q >>> 30);
			phbm_pkg::S_DD: t2_q <= 32'(prod_q >>> 30);
			phbm_pkg::S_DF: begin
				a_q <= a_cl;
				sq_v_q <= a_cl;
				sq_r_q <= '0;
			end
			phbm_pkg::S_SQRT: begin
				if (sq_k_q == '0) begin
					if (!sq_sel_q) begin
						sa_q <= sq_r_n[30:0];
						sq_v_q <= phbm_pkg::ONE_Q60[60:0] - a_q;
						sq_r_q <= '0;
					end else begin
						ca_q <= sq_r_n[30:0];
					end
				end else begin
					sq_v_q <= sq_v_n;
					sq_r_q <= sq_r_n;
				end
			end
			phbm_pkg::S_DLOAD: begin
				cx_q <= {33'b0, ca_q};
				cy_q <= {33'b0, sa_q};
				cz_q <= '0;
				rot_q <= 1'b0;
			end
			phbm_pkg::S_DQ: dist_q <= dq;
			phbm_pkg::S_BB: yb_q <= prod_q[63:0];
			phbm_pkg::S_BC: acc_q <= prod_q[63:0];
			phbm_pkg::S_BD: t1_q <= 32'(prod_q >>> 30);
			phbm_pkg::S_BF: xb_q <= xb_n;
			phbm_pkg::S_BLOAD: begin
				rot_q <= 1'b0;
				if (xb_q < 0) begin
					cz_q <= yb_q[63] ? -phbm_pkg::PI_Q30 : phbm_pkg::PI_Q30;
					cx_q <= -xb_q;
					cy_q <= -yb_q;
				end else begin
					cz_q <= '0;
					cx_q <= xb_q;
					cy_q <= yb_q;
				end
			end
			phbm_pkg::S_BG: zneg_q <= cz_q[ZW-1];
			phbm_pkg::S_BH: bear_q <= bear_n;
			phbm_pkg::S_FIN: if (last_q && out_free) m_data_q <= out_word;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) matched_q <= checked_q)
		else $error("match count exceeds candidate count");

	assert property (@(posedge clk) disable iff (!arst_n) checked_q <= CNT_W'(SCAN_CAP))
		else $error("candidate count beyond scan cap");

	assert property (@(posedge clk) disable iff (!arst_n)
		(matched_q == '0) == (best_id_q == '0))
		else $error("best match record out of step with match count");

endmodule
